@@ hdl/bfpa_pkg.sv @@
package bfpa_pkg;

    // Pool geometry: offsets are 12 bits wide, so the pool is 4096 bytes
    localparam int OFS_W       = 12;
    localparam int LEN_W       = 13;
    localparam int POOL_BYTES  = 1 << OFS_W;
    localparam int HDR_BYTES   = 8;
    localparam int TABLE_DEPTH_DEF = 64;

    // Stream beat widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One free extent: base offset and length in bytes
    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [LEN_W-1:0] length;
    } extent_t;

    // Control from the sequencer to the best-fit tracker
    typedef struct packed {
        logic clear;
        logic sample;
    } track_ctl_t;

endpackage

@@ hdl/bfpa_extent_mem.sv @@
module bfpa_extent_mem
    import bfpa_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output extent_t          rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  extent_t          wr_data
);

    extent_t mem [TABLE_DEPTH];
    extent_t mem_q_reg;
    logic    fresh0_reg;
    logic    use_init_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Entry 0 reads as the whole pool until it is first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh0_reg   <= 1'b1;
            use_init_reg <= 1'b0;
        end else begin
            if (wr_en && wr_addr == '0) begin
                fresh0_reg <= 1'b0;
            end
            if (rd_en) begin
                use_init_reg <= fresh0_reg && rd_addr == '0;
            end
        end
    end

    always_comb begin
        if (use_init_reg) begin
            rd_data.start  = '0;
            rd_data.length = LEN_W'(POOL_BYTES);
        end else begin
            rd_data = mem_q_reg;
        end
    end

endmodule

@@ hdl/bfpa_header_mem.sv @@
module bfpa_header_mem
    import bfpa_pkg::*;
(
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [OFS_W-1:0] rd_addr,
    output logic [LEN_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [OFS_W-1:0] wr_addr,
    input  logic [LEN_W-1:0] wr_data
);

    logic [LEN_W-1:0] mem [POOL_BYTES];
    logic [LEN_W-1:0] rd_data_reg;

    // Block sizes by base offset; entries hold garbage until written
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/bfpa_best_track.sv @@
module bfpa_best_track
    import bfpa_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  track_ctl_t       ctl,
    input  logic [IDX_W-1:0] cand_idx,
    input  extent_t          cand,
    input  logic [LEN_W-1:0] need,
    output logic             found,
    output logic [IDX_W-1:0] best_idx,
    output extent_t          best
);

    logic             found_reg;
    logic [IDX_W-1:0] idx_reg;
    extent_t          best_reg;
    logic             hit;

    // Strictly smaller wins, so the lowest index keeps a tie
    assign hit = cand.length >= need && (!found_reg || cand.length < best_reg.length);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.clear) begin
            found_reg <= 1'b0;
        end else if (ctl.sample && hit) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctl.clear && ctl.sample && hit) begin
            idx_reg  <= cand_idx;
            best_reg <= cand;
        end
    end

    assign found    = found_reg;
    assign best_idx = idx_reg;
    assign best     = best_reg;

endmodule

@@ hdl/best_fit_pool_allocator.sv @@
// Allocation: N table reads, N = extents in use (1..TABLE_DEPTH), then the last compare
// drains, the decide state picks the best fit and the result is queued.
// Free: the header store read gives the block size, then the extent is appended; a free
// on a full table skips both and reports table-full status. One request in flight; the
// next is taken the cycle after the result is queued, and an output stall holds it back.
// Reset: synchronous, active low; one extent spans the pool; the header store is not cleared.
module best_fit_pool_allocator
    import bfpa_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // request_size[11:0], free_offset[23:12]
    input  logic                s_axis_tuser,   // mode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // user_offset[11:0], zero pad
    output logic [1:0]          m_axis_tuser    // status
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FREE_RD,
        S_FREE_WR,
        S_RESP
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [LEN_W-1:0] need_reg, need_next;
    logic [OFS_W-1:0] base_reg, base_next;
    logic [OFS_W-1:0] res_ofs_reg, res_ofs_next;
    status_t          res_st_reg, res_st_next;
    logic             out_valid_reg, out_valid_next;
    logic [OFS_W-1:0] out_ofs_reg, out_ofs_next;
    status_t          out_st_reg, out_st_next;

    logic             s_fire;
    logic             issue;
    logic [OFS_W-1:0] in_req;
    logic [OFS_W-1:0] in_foff;
    mode_t            in_mode;

    logic             ext_rd_en;
    logic [IDX_W-1:0] ext_rd_addr;
    extent_t          ext_rd_data;
    logic             ext_wr_en;
    logic [IDX_W-1:0] ext_wr_addr;
    extent_t          ext_wr_data;

    logic             hdr_rd_en;
    logic [LEN_W-1:0] hdr_rd_data;
    logic             hdr_wr_en;

    track_ctl_t       trk_ctl;
    logic             best_found;
    logic [IDX_W-1:0] best_idx;
    extent_t          best_ext;

    assign in_req  = s_axis_tdata[OFS_W-1:0];
    assign in_foff = s_axis_tdata[2*OFS_W-1:OFS_W];
    assign in_mode = mode_t'(s_axis_tuser);

    assign s_axis_tready = state_reg == S_IDLE;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign issue         = state_reg == S_SCAN && rd_cnt_reg != cnt_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W-OFS_W){1'b0}}, out_ofs_reg};
    assign m_axis_tuser  = out_st_reg;

    // Memory ports
    assign ext_rd_en   = issue;
    assign ext_rd_addr = rd_cnt_reg[IDX_W-1:0];
    assign hdr_rd_en   = state_reg == S_FREE_RD;
    assign hdr_wr_en   = state_reg == S_DECIDE && best_found;

    always_comb begin
        ext_wr_en   = 1'b0;
        ext_wr_addr = best_idx;
        ext_wr_data.start  = OFS_W'({1'b0, best_ext.start} + need_reg);
        ext_wr_data.length = best_ext.length - need_reg;
        if (state_reg == S_DECIDE && best_found) begin
            ext_wr_en = 1'b1;
        end else if (state_reg == S_FREE_WR) begin
            ext_wr_en          = 1'b1;
            ext_wr_addr        = cnt_reg[IDX_W-1:0];
            ext_wr_data.start  = base_reg;
            ext_wr_data.length = hdr_rd_data;
        end
    end

    assign trk_ctl.clear  = s_fire;
    assign trk_ctl.sample = pend_reg;

    // Sequencer next state
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = rd_cnt_reg[IDX_W-1:0];
        need_next      = need_reg;
        base_next      = base_reg;
        res_ofs_next   = res_ofs_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_ofs_next   = out_ofs_reg;
        out_st_next    = out_st_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    need_next    = LEN_W'(in_req) + LEN_W'(HDR_BYTES);
                    base_next    = in_foff - OFS_W'(HDR_BYTES);
                    rd_cnt_next  = '0;
                    res_ofs_next = '0;
                    res_st_next  = ST_OK;
                    if (in_mode == MODE_ALLOC) begin
                        state_next = S_SCAN;
                    end else if (cnt_reg == CNT_W'(TABLE_DEPTH)) begin
                        res_st_next = ST_FULL;
                        state_next  = S_RESP;
                    end else begin
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_SCAN: begin
                // Stream one table read per cycle, then drain the last compare
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    pend_next   = 1'b1;
                end else if (!pend_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (best_found) begin
                    res_ofs_next = best_ext.start + OFS_W'(HDR_BYTES);
                end else begin
                    res_st_next = ST_NOFIT;
                end
                state_next = S_RESP;
            end
            S_FREE_RD: begin
                state_next = S_FREE_WR;
            end
            S_FREE_WR: begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_ofs_next   = res_ofs_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= CNT_W'(1);
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
        pend_idx_reg <= pend_idx_next;
        need_reg     <= need_next;
        base_reg     <= base_next;
        res_ofs_reg  <= res_ofs_next;
        res_st_reg   <= res_st_next;
        out_ofs_reg  <= out_ofs_next;
        out_st_reg   <= out_st_next;
    end

    bfpa_extent_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_extent_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (ext_rd_en),
        .rd_addr (ext_rd_addr),
        .rd_data (ext_rd_data),
        .wr_en   (ext_wr_en),
        .wr_addr (ext_wr_addr),
        .wr_data (ext_wr_data)
    );

    bfpa_header_mem u_header_mem (
        .aclk    (aclk),
        .rd_en   (hdr_rd_en),
        .rd_addr (base_reg),
        .rd_data (hdr_rd_data),
        .wr_en   (hdr_wr_en),
        .wr_addr (best_ext.start),
        .wr_data (need_reg)
    );

    bfpa_best_track #(
        .IDX_W (IDX_W)
    ) u_best_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (trk_ctl),
        .cand_idx (pend_idx_reg),
        .cand     (ext_rd_data),
        .need     (need_reg),
        .found    (best_found),
        .best_idx (best_idx),
        .best     (best_ext)
    );

    // Extent count stays within the table
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(TABLE_DEPTH) && cnt_reg != '0)
        else $error("extent count out of range");

    // Extent count only grows, one step at a time
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != $past(cnt_reg) |-> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("extent count jumped");

    // A chosen extent always holds the request
    a_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DECIDE && best_found |-> best_ext.length >= need_reg)
        else $error("chosen extent too small");

    // Table-full status only when the table is full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESP && res_st_reg == ST_FULL |-> cnt_reg == CNT_W'(TABLE_DEPTH))
        else $error("table full reported early");

    // Scan never reads past the extents in use
    a_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> rd_cnt_reg <= cnt_reg)
        else $error("scan overran table");

endmodule

@@ bench/best_fit_pool_allocator_test.sv @@
module best_fit_pool_allocator_test;
    import bfpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int PHASE_ITEMS     = 450;

    // One allocator answer as it appears on the result channel
    typedef struct packed {
        logic [OFS_W-1:0] user_offset;
        status_t          status;
    } alloc_result_t;

    // One directed request; typed rows carry their answer, others use the pool model
    typedef struct packed {
        mode_t            mode;
        logic [OFS_W-1:0] size;
        logic [OFS_W-1:0] offset;
        logic             typed;
        logic [OFS_W-1:0] exp_offset;
        status_t          exp_status;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 16;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // whole pool in one block, then nothing left
        '{MODE_ALLOC, 12'd4088, 12'd4095, 1'b1, 12'd8, ST_OK},
        '{MODE_ALLOC, 12'd0,    12'd8,    1'b1, 12'd0, ST_NOFIT},
        '{MODE_FREE,  12'd4088, 12'd8,    1'b1, 12'd0, ST_OK},
        // leave an 8-byte tail, then a zero-size block at the pool end
        '{MODE_ALLOC, 12'd4080, 12'd8,    1'b0, 12'd0, ST_OK},
        '{MODE_ALLOC, 12'd0,    12'd4095, 1'b0, 12'd0, ST_OK},
        '{MODE_ALLOC, 12'd0,    12'd8,    1'b0, 12'd0, ST_OK},
        // free with an offset below the header size wraps to the pool end
        '{MODE_FREE,  12'd0,    12'd0,    1'b1, 12'd0, ST_OK},
        '{MODE_FREE,  12'd0,    12'd8,    1'b1, 12'd0, ST_OK},
        // double free appends a duplicate extent
        '{MODE_FREE,  12'd2048, 12'd8,    1'b1, 12'd0, ST_OK},
        // tie between equal extents, then an exact fit
        '{MODE_ALLOC, 12'd100,  12'd2048, 1'b0, 12'd0, ST_OK},
        '{MODE_ALLOC, 12'd0,    12'd8,    1'b0, 12'd0, ST_OK},
        '{MODE_ALLOC, 12'd2047, 12'd1365, 1'b0, 12'd0, ST_OK},
        '{MODE_FREE,  12'd1365, 12'd116,  1'b1, 12'd0, ST_OK},
        '{MODE_ALLOC, 12'd4088, 12'd2730, 1'b0, 12'd0, ST_OK},
        '{MODE_ALLOC, 12'd1365, 12'd2730, 1'b0, 12'd0, ST_OK},
        '{MODE_ALLOC, 12'd2730, 12'd1365, 1'b0, 12'd0, ST_OK}
    };

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;   // request_size[11:0], free_offset[23:12]
    logic                s_axis_tuser  = 1'b0; // mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;         // user_offset[11:0], zero pad
    logic [1:0]          m_axis_tuser;         // status

    // Pool model state
    logic [OFS_W-1:0] ext_base [TABLE_DEPTH_DEF];
    logic [LEN_W-1:0] ext_len  [TABLE_DEPTH_DEF];
    int               ext_count;
    logic [LEN_W-1:0] hdr_size    [POOL_BYTES];
    bit               hdr_written [POOL_BYTES];
    logic [OFS_W-1:0] written_bases [$];
    logic [OFS_W-1:0] live_blocks [$];

    alloc_result_t expected_results [$];

    int sender_gap_pct   = 0;
    int receiver_gap_pct = 0;
    int hold_offs_asked  = 0;
    int hold_offs_done   = 0;
    int stall_left       = 0;
    int quiet_cycles     = 0;
    int mismatch_count   = 0;
    int requests_sent    = 0;
    int allocs_ok        = 0;
    int allocs_nofit     = 0;
    int frees_ok         = 0;
    int frees_full       = 0;

    best_fit_pool_allocator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Put the pool model in its after-reset state
    task automatic clear_pool_model();
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            ext_base[i] = '0;
            ext_len[i]  = '0;
        end
        ext_len[0] = LEN_W'(POOL_BYTES);
        ext_count  = 1;
        for (int i = 0; i < POOL_BYTES; i++) begin
            hdr_size[i]    = '0;
            hdr_written[i] = 1'b0;
        end
    endtask

    // Best-fit search and table update for one request; returns its answer
    function automatic alloc_result_t serve_request(input mode_t mode,
                                                    input logic [OFS_W-1:0] size,
                                                    input logic [OFS_W-1:0] ofs);
        alloc_result_t    res;
        logic [LEN_W-1:0] need;
        logic [OFS_W-1:0] base;
        int               best;
        res.user_offset = '0;
        res.status      = ST_OK;
        best            = -1;
        if (mode == MODE_ALLOC) begin
            need = LEN_W'(size) + LEN_W'(HDR_BYTES);
            for (int i = 0; i < ext_count; i++) begin
                if (ext_len[i] >= need) begin
                    if (best < 0) begin
                        best = i;
                    end else if (ext_len[i] < ext_len[best]) begin
                        best = i;
                    end
                end
            end
            if (best < 0) begin
                res.status = ST_NOFIT;
            end else begin
                base           = ext_base[best];
                hdr_size[base] = need;
                if (!hdr_written[base]) begin
                    hdr_written[base] = 1'b1;
                    written_bases.push_back(base);
                end
                ext_base[best]  = base + OFS_W'(need);
                ext_len[best]   = ext_len[best] - need;
                res.user_offset = base + OFS_W'(HDR_BYTES);
            end
        end else if (ext_count >= TABLE_DEPTH_DEF) begin
            res.status = ST_FULL;
        end else begin
            base               = ofs - OFS_W'(HDR_BYTES);
            ext_base[ext_count] = base;
            ext_len[ext_count]  = hdr_size[base];
            ext_count++;
        end
        return res;
    endfunction

    // Offer one request beat, wait for its acceptance, queue its answer
    task automatic issue_request(input mode_t mode, input logic [OFS_W-1:0] size,
                                 input logic [OFS_W-1:0] ofs, input bit typed,
                                 input alloc_result_t typed_res);
        alloc_result_t res;
        @(negedge aclk);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ofs, size};
        s_axis_tuser  <= mode;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        res = serve_request(mode, size, ofs);
        // Tally each request by kind and outcome
        if (mode == MODE_ALLOC) begin
            if (res.status == ST_OK) begin
                live_blocks.push_back(res.user_offset);
                allocs_ok++;
            end else begin
                allocs_nofit++;
            end
        end else if (res.status == ST_FULL) begin
            frees_full++;
        end else begin
            frees_ok++;
        end
        expected_results.push_back(typed ? typed_res : res);
        requests_sent++;
    endtask

    // Mostly allocations and frees of live blocks, some stale or repeated frees
    task automatic issue_random_request();
        mode_t            mode;
        logic [OFS_W-1:0] size;
        logic [OFS_W-1:0] ofs;
        int               roll;
        int               pick;
        alloc_result_t    none;
        none = '0;
        roll = $urandom_range(99);
        if (roll < 55 || written_bases.size() == 0) begin
            mode = MODE_ALLOC;
            ofs  = OFS_W'($urandom_range(4095, 8));
            pick = $urandom_range(99);
            if (pick < 70)
                size = OFS_W'($urandom_range(56, 0));
            else if (pick < 93)
                size = OFS_W'($urandom_range(600, 57));
            else
                size = OFS_W'($urandom_range(4088, 601));
        end else begin
            mode = MODE_FREE;
            size = OFS_W'($urandom_range(4088, 0));
            if (roll < 93 && live_blocks.size() != 0) begin
                pick = $urandom_range(live_blocks.size() - 1);
                ofs  = live_blocks[pick];
                live_blocks.delete(pick);
            end else begin
                pick = $urandom_range(written_bases.size() - 1);
                ofs  = written_bases[pick] + OFS_W'(HDR_BYTES);
            end
        end
        issue_request(mode, size, ofs, 1'b0, none);
    endtask

    // Receiver: random stalls, plus a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_offs_done != hold_offs_asked) begin
            hold_offs_done = hold_offs_asked;
            stall_left     = HOLD_OFF_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_gap_pct);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result beat offset=%0d status=%0d with none pending",
                                          m_axis_tdata[OFS_W-1:0], m_axis_tuser));
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[OFS_W-1:0] !== want.user_offset)
                    report_mismatch($sformatf("user_offset got %0d want %0d",
                                              m_axis_tdata[OFS_W-1:0], want.user_offset));
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_axis_tuser, want.status));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("** best_fit_pool_allocator: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        alloc_result_t typed_res;
        clear_pool_model();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows, sender rarely idle, receiver mostly idle
        sender_gap_pct   = 6;
        receiver_gap_pct = 81;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            typed_res.user_offset = DIRECTED[r].exp_offset;
            typed_res.status      = DIRECTED[r].exp_status;
            issue_request(DIRECTED[r].mode, DIRECTED[r].size, DIRECTED[r].offset,
                          DIRECTED[r].typed, typed_res);
        end

        // Random traffic: slow receiver, then slow sender, then full rate with a long receiver hold-off
        sender_gap_pct   = 6;
        receiver_gap_pct = 81;
        repeat (PHASE_ITEMS) issue_random_request();
        sender_gap_pct   = 81;
        receiver_gap_pct = 6;
        repeat (PHASE_ITEMS) issue_random_request();
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
        hold_offs_asked++;
        repeat (PHASE_ITEMS) issue_random_request();

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray beat
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Ran %0d requests: %0d good allocations, %0d without a fit, %0d frees,",
                 requests_sent, allocs_ok, allocs_nofit, frees_ok);
        $display("%0d frees dropped on a full table, %0d extents in use at the end",
                 frees_full, ext_count);
        if (mismatch_count == 0) begin
            $display("** best_fit_pool_allocator: PASSED **");
        end else begin
            $display("** best_fit_pool_allocator: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bfpa_pkg.sv
hdl/bfpa_extent_mem.sv
hdl/bfpa_header_mem.sv
hdl/bfpa_best_track.sv
hdl/best_fit_pool_allocator.sv
bench/best_fit_pool_allocator_test.sv
